>>> hw/rtl/assert_macros.svh
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TTPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define TTPS_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/ttps_pkg.sv
package ttps_pkg;

    localparam int KEY_W   = 64;
    localparam int SCORE_W = 18;
    localparam int DEPTH_W = 8;
    localparam int KIND_W  = 2;
    localparam int SQ_W    = 7;
    localparam int PROMO_W = 8;
    localparam int MOVE_W  = 2 * SQ_W + PROMO_W;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int TABLE_ENTRIES_MAX = 16777216;

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_PROBE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOWER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPPER = 2'd2;

    localparam int S_DATA_W = 152;
    localparam int M_DATA_W = 48;

    // Input transaction payload, first field in the low bits.
    typedef struct packed {
        logic [1:0]         pad;
        logic [PROMO_W-1:0] move_promotion;
        logic [SQ_W-1:0]    move_target;
        logic [SQ_W-1:0]    move_origin;
        logic [SCORE_W-1:0] beta_bound;
        logic [SCORE_W-1:0] alpha_bound;
        logic [KIND_W-1:0]  bound_kind;
        logic [DEPTH_W-1:0] search_depth;
        logic [SCORE_W-1:0] score_in;
        logic [KEY_W-1:0]   position_key;
    } req_t;

    typedef struct packed {
        logic [5:0]         pad;
        logic [PROMO_W-1:0] best_promotion;
        logic [SQ_W-1:0]    best_target;
        logic [SQ_W-1:0]    best_origin;
        logic [SCORE_W-1:0] score_out;
        logic               move_valid;
        logic               hit;
    } result_t;

    // One table slot; move packs origin low, then target, then promotion.
    typedef struct packed {
        logic [MOVE_W-1:0]  move;
        logic [KIND_W-1:0]  kind;
        logic [DEPTH_W-1:0] depth;
        logic [SCORE_W-1:0] score;
        logic [KEY_W-1:0]   key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> hw/rtl/ttps_slot_mod.sv
// Slot index = key mod TABLE_ENTRIES. Power of two: low bits, ready the cycle
// after start. Otherwise the key is folded in a byte at a time, MSB first,
// each byte going through a reciprocal quotient estimate, a subtract and one
// corrective subtract; done rises after the last byte.
module ttps_slot_mod
    import ttps_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [KEY_W-1:0]                 key,
    output logic                             done,
    output logic [$clog2(TABLE_ENTRIES)-1:0] rem
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int X_W     = 32;
    localparam int BYTE_W  = 8;
    localparam int NBYTES  = KEY_W / BYTE_W;
    localparam int CNT_W   = $clog2(NBYTES);
    localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
    localparam logic [X_W-1:0] N_X = X_W'(TABLE_ENTRIES);
    // floor(2^32 / N): the estimate is the true quotient or one short
    localparam logic [X_W-1:0] RECIP = X_W'((64'd1 << X_W) / 64'(TABLE_ENTRIES));

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_EST  = 4'b0010,
        PH_SUB  = 4'b0100,
        PH_FIX  = 4'b1000
    } phase_t;

    phase_t             phase_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [KEY_W-1:0]   sh_reg;
    logic [IDX_W-1:0]   rem_reg;
    logic [X_W-1:0]     x_reg;
    logic [BYTE_W-1:0]  q_reg;
    logic [X_W-1:0]     diff_reg;
    logic [X_W-1:0]     x_next;
    logic [2*X_W-1:0]   prod;
    logic [X_W-1:0]     qn;
    logic [IDX_W-1:0]   rem_fix;

    // rem < N <= 2^24, so rem:byte always fits 32 bits
    always_comb
    begin
        x_next = X_W'({rem_reg, sh_reg[KEY_W-1 -: BYTE_W]});
        prod   = {{X_W{1'b0}}, x_next} * {{X_W{1'b0}}, RECIP};
        qn     = X_W'(q_reg) * N_X;
        if (diff_reg >= N_X)
        begin
            rem_fix = IDX_W'(diff_reg - N_X);
        end
        else
        begin
            rem_fix = IDX_W'(diff_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                if (IS_POW2)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    phase_reg <= PH_EST;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE: phase_reg <= PH_IDLE;
                    PH_EST:  phase_reg <= PH_SUB;
                    PH_SUB:  phase_reg <= PH_FIX;
                    PH_FIX:
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == CNT_W'(NBYTES - 1))
                        begin
                            phase_reg <= PH_IDLE;
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            phase_reg <= PH_EST;
                        end
                    end
                    default: phase_reg <= PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg <= key;
            if (IS_POW2)
            begin
                rem_reg <= key[IDX_W-1:0];
            end
            else
            begin
                rem_reg <= '0;
            end
        end
        else if (phase_reg == PH_EST)
        begin
            x_reg  <= x_next;
            q_reg  <= prod[X_W +: BYTE_W];
            sh_reg <= {sh_reg[KEY_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
        end
        else if (phase_reg == PH_SUB)
        begin
            diff_reg <= x_reg - qn;
        end
        else if (phase_reg == PH_FIX)
        begin
            rem_reg <= rem_fix;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

>>> hw/rtl/transposition_table_probe_store.sv
// Direct-mapped transposition table with one single-port-style RAM of
// TABLE_ENTRIES slots (key, score, depth, bound kind, best move). Each input
// transaction is a store (tuser 0) or a probe (tuser 1); a probe yields one
// result transaction, a store none. Items are handled one at a time: accept,
// slot index, RAM read, then compare and write-back or result load. The slot
// index is the low key bits when TABLE_ENTRIES is a power of two, else a
// byte-wise remainder over the 64-bit key. After reset the RAM is cleared one
// slot per cycle, so the input side stays not ready until every slot is
// cleared. A finished probe result sits in an output register, so the next
// item is accepted while it waits; that item stalls only when its own result
// would overwrite a result not yet taken.
module transposition_table_probe_store
    import ttps_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // position_key, score_in, search_depth, bound_kind, alpha_bound,
    // beta_bound, move_origin, move_target, move_promotion, zero pad
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // action
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // hit, move_valid, score_out, best_origin, best_target,
    // best_promotion, zero pad
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        ST_CLEAR   = 4'b0001,
        ST_IDLE    = 4'b0010,
        ST_INDEX   = 4'b0100,
        ST_RESOLVE = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   clr_reg;
    logic [IDX_W-1:0]   idx_reg;
    req_t               req_reg;
    logic               act_reg;
    entry_t             rd_data_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    result_t            m_data_reg;

    entry_t             mem [TABLE_ENTRIES];

    logic               accept;
    logic               idx_done;
    logic [IDX_W-1:0]   idx_rem;
    logic               key_match;
    logic               keep_slot;
    logic               valid;
    logic               cutoff;
    logic               out_free;
    logic               load_result;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    entry_t             new_entry;
    result_t            res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    ttps_slot_mod #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_slot_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (s_axis_tdata[KEY_W-1:0]),
        .done  (idx_done),
        .rem   (idx_rem)
    );

    // Compare the slot read back against the pending request.
    always_comb
    begin
        key_match = (rd_data_reg.key == req_reg.position_key);
        keep_slot = key_match && (rd_data_reg.depth > req_reg.search_depth);
        valid     = key_match && (rd_data_reg.depth >= req_reg.search_depth);
        unique case (rd_data_reg.kind)
            KIND_EXACT: cutoff = 1'b1;
            KIND_LOWER: cutoff = $signed(rd_data_reg.score) >= $signed(req_reg.beta_bound);
            KIND_UPPER: cutoff = $signed(rd_data_reg.score) <= $signed(req_reg.alpha_bound);
            default:    cutoff = 1'b0;
        endcase

        res                = '0;
        res.hit            = valid && cutoff;
        res.move_valid     = valid;
        res.score_out      = (valid && cutoff) ? rd_data_reg.score : '0;
        res.best_origin    = valid ? rd_data_reg.move[SQ_W-1:0] : '1;
        res.best_target    = valid ? rd_data_reg.move[2*SQ_W-1:SQ_W] : '1;
        res.best_promotion = valid ? rd_data_reg.move[MOVE_W-1:2*SQ_W] : '0;

        new_entry.key   = req_reg.position_key;
        new_entry.score = req_reg.score_in;
        new_entry.depth = req_reg.search_depth;
        new_entry.kind  = req_reg.bound_kind;
        new_entry.move  = {req_reg.move_promotion, req_reg.move_target, req_reg.move_origin};
    end

    assign out_free    = !m_valid_reg || m_axis_tready;
    assign load_result = (state_reg == ST_RESOLVE) && (act_reg == ACT_PROBE) && out_free;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = new_entry;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if ((state_reg == ST_RESOLVE) && (act_reg == ACT_STORE) && !keep_slot)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                if (idx_done)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if ((act_reg == ACT_STORE) || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (load_result)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_t'(s_axis_tdata);
            act_reg <= s_axis_tuser;
        end
        if ((state_reg == ST_INDEX) && idx_done)
        begin
            idx_reg <= idx_rem;
        end
        if (load_result)
        begin
            m_data_reg <= res;
        end
    end

    // Table RAM: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if ((state_reg == ST_INDEX) && idx_done)
        begin
            rd_data_reg <= mem[idx_rem];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

>>> hw/rtl/ttps_checker.sv
`include "assert_macros.svh"

module ttps_checker
    import ttps_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata
);

    result_t res;

    assign res = result_t'(m_axis_tdata);

    // Stalled result transaction holds.
    `TTPS_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // Table clear runs right after reset, no input taken then.
    `TTPS_ASSERT(a_clear_busy, clk, rst_n, !$past(rst_n) |-> !s_axis_tready, "input ready during table clear")

    `TTPS_NEVER(a_hit_valid, clk, rst_n, m_axis_tvalid && res.hit && !res.move_valid, "hit without key match")

    `TTPS_NEVER(a_score_zero, clk, rst_n, m_axis_tvalid && !res.hit && (res.score_out != '0), "score shown without cutoff")

    `TTPS_NEVER(a_miss_fmt, clk, rst_n, m_axis_tvalid && !res.move_valid && ((res.best_origin != '1) || (res.best_target != '1) || (res.best_promotion != '0)), "miss result carries a move")

endmodule

bind transposition_table_probe_store ttps_checker u_ttps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> verif/tb_transposition_table_probe_store.sv
module tb_transposition_table_probe_store
    import ttps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES     = 9;
    localparam int RANDOM_PER_PHASE = 160;
    localparam int SETTLE_CYCLES    = 16;
    localparam int RUN_LIMIT        = 300000;
    localparam int KEY_POOL_SIZE    = 16;
    localparam logic [KIND_W-1:0] KIND_UNDEF = 2'd3;

    typedef struct packed {
        logic act;
        req_t req;
    } table_request_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                s_axis_tuser = ACT_STORE;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    table_request_t pending_requests[$];
    result_t        expected_probe_results[$];
    entry_t         tt_slots [TABLE_ENTRIES_DEF] = '{default: '0};
    logic [63:0]    key_pool [KEY_POOL_SIZE];

    int mismatches = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always #2 clk = ~clk;

    transposition_table_probe_store u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Depth-preferred replacement on store; key/depth match and window test on probe.
    function automatic void update_table(input logic act, input req_t r);
        int unsigned idx;
        entry_t      e;
        result_t     res;
        idx = 32'(r.position_key % 64'(TABLE_ENTRIES_DEF));
        e = tt_slots[idx];
        if (act == ACT_STORE)
        begin
            if (!(e.key == r.position_key && e.depth > r.search_depth))
            begin
                e.key   = r.position_key;
                e.score = r.score_in;
                e.depth = r.search_depth;
                e.kind  = r.bound_kind;
                e.move  = {r.move_promotion, r.move_target, r.move_origin};
                tt_slots[idx] = e;
            end
        end
        else
        begin
            res = '0;
            res.best_origin = '1;
            res.best_target = '1;
            if (e.key == r.position_key && e.depth >= r.search_depth)
            begin
                res.move_valid     = 1'b1;
                res.best_origin    = e.move[SQ_W-1:0];
                res.best_target    = e.move[2*SQ_W-1:SQ_W];
                res.best_promotion = e.move[MOVE_W-1:2*SQ_W];
                if (e.kind == KIND_EXACT
                    || (e.kind == KIND_LOWER && $signed(e.score) >= $signed(r.beta_bound))
                    || (e.kind == KIND_UPPER && $signed(e.score) <= $signed(r.alpha_bound)))
                begin
                    res.hit       = 1'b1;
                    res.score_out = e.score;
                end
            end
            expected_probe_results.push_back(res);
        end
    endfunction

    function automatic logic [SQ_W-1:0] rand_square();
        int unsigned v;
        v = $urandom_range(0, 64);
        return (v == 64) ? '1 : SQ_W'(v);
    endfunction

    // Often small scores, plus the extremes, so window edges land near stored scores.
    function automatic logic [SCORE_W-1:0] rand_score();
        case ($urandom_range(0, 9))
            0: return 18'h20000;
            1: return 18'h1FFFF;
            2, 3, 4, 5: return SCORE_W'($urandom_range(0, 16) - 8);
            default: return SCORE_W'($urandom);
        endcase
    endfunction

    function automatic logic [DEPTH_W-1:0] rand_depth();
        if ($urandom_range(0, 7) == 0)
            return DEPTH_W'($urandom_range(0, 255));
        return DEPTH_W'($urandom_range(0, 7));
    endfunction

    task automatic queue_store(input logic [KEY_W-1:0] key, input logic [SCORE_W-1:0] score,
                               input logic [DEPTH_W-1:0] depth, input logic [KIND_W-1:0] kind,
                               input logic [SQ_W-1:0] origin, input logic [SQ_W-1:0] target,
                               input logic [PROMO_W-1:0] promo);
        table_request_t t;
        t.act                = ACT_STORE;
        t.req                = '0;
        t.req.position_key   = key;
        t.req.score_in       = score;
        t.req.search_depth   = depth;
        t.req.bound_kind     = kind;
        t.req.alpha_bound    = SCORE_W'($urandom);
        t.req.beta_bound     = SCORE_W'($urandom);
        t.req.move_origin    = origin;
        t.req.move_target    = target;
        t.req.move_promotion = promo;
        pending_requests.push_back(t);
    endtask

    // Store-only fields carry noise on a probe; the block must ignore them.
    task automatic queue_probe(input logic [KEY_W-1:0] key, input logic [DEPTH_W-1:0] depth,
                               input logic [SCORE_W-1:0] alpha, input logic [SCORE_W-1:0] beta);
        table_request_t t;
        t.act                = ACT_PROBE;
        t.req                = '0;
        t.req.position_key   = key;
        t.req.score_in       = SCORE_W'($urandom);
        t.req.search_depth   = depth;
        t.req.bound_kind     = KIND_W'($urandom);
        t.req.alpha_bound    = alpha;
        t.req.beta_bound     = beta;
        t.req.move_origin    = SQ_W'($urandom);
        t.req.move_target    = SQ_W'($urandom);
        t.req.move_promotion = PROMO_W'($urandom);
        pending_requests.push_back(t);
    endtask

    task automatic queue_random_item();
        logic [KEY_W-1:0]  key;
        logic [KIND_W-1:0] kind;
        if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        else
            key = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 55)
        begin
            kind = ($urandom_range(0, 19) == 0) ? KIND_UNDEF : KIND_W'($urandom_range(0, 2));
            queue_store(key, rand_score(), rand_depth(), kind, rand_square(), rand_square(),
                        PROMO_W'($urandom));
        end
        else
            queue_probe(key, rand_depth(), rand_score(), rand_score());
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    // Driver: predicts on every accepted transaction, then loads the next one.
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                update_table(s_axis_tuser, req_t'(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_requests.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_requests[0].act;
                    s_axis_tdata  <= pending_requests[0].req;
                    void'(pending_requests.pop_front());
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        result_t got, want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata);
                if (expected_probe_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result transaction, expected none actual %h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = expected_probe_results.pop_front();
                    check_field("hit", 64'(want.hit), 64'(got.hit));
                    check_field("move_valid", 64'(want.move_valid), 64'(got.move_valid));
                    check_field("score_out", 64'(want.score_out), 64'(got.score_out));
                    check_field("best_origin", 64'(want.best_origin), 64'(got.best_origin));
                    check_field("best_target", 64'(want.best_target), 64'(got.best_target));
                    check_field("best_promotion", 64'(want.best_promotion),
                                64'(got.best_promotion));
                    check_field("pad", 64'(want.pad), 64'(got.pad));
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [KEY_W-1:0] ka, kb, kb_alias, kc;
        logic [31:0]      rnd;
        ka       = 64'hFFFF_FFFF_FFFF_FFFF;
        kb       = 64'h8000_0000_0000_0123;
        kb_alias = 64'h0000_0000_0000_1123;
        kc       = 64'h5A5A_A5A5_0F0F_0456;

        // pairs of keys sharing a slot so replacement and aliasing get exercised
        for (int i = 0; i < KEY_POOL_SIZE; i += 2)
        begin
            rnd             = $urandom;
            key_pool[i]     = {$urandom, $urandom};
            key_pool[i + 1] = {$urandom, rnd[31:12], key_pool[i][11:0]};
        end

        // cleared slot behaves as key 0, depth 0, exact bound
        queue_probe(64'd0, 8'd0, 18'h20000, 18'h1FFFF);
        queue_probe(64'd0, 8'd1, 18'd0, 18'd0);
        queue_probe(64'h1000, 8'd0, 18'd0, 18'd0);
        queue_store(ka, 18'h1FFFF, 8'd255, KIND_EXACT, 7'd63, 7'h7F, 8'hFF);
        queue_probe(ka, 8'd255, 18'h20000, 18'h1FFFF);
        // shallower store of the same key must not replace
        queue_store(ka, 18'h3FFFB, 8'd10, KIND_LOWER, 7'd1, 7'd2, 8'd3);
        queue_probe(ka, 8'd0, 18'd0, 18'd0);
        queue_store(kb, 18'h20000, 8'd5, KIND_LOWER, 7'd0, 7'd0, 8'd0);
        queue_probe(kb, 8'd5, 18'd0, 18'h20000);
        queue_probe(kb, 8'd5, 18'd0, 18'h20001);
        queue_probe(kb, 8'd6, 18'd0, 18'h20000);
        queue_store(kc, 18'd100, 8'd5, KIND_UPPER, 7'd12, 7'd28, 8'h71);
        queue_probe(kc, 8'd3, 18'd100, 18'h1FFFF);
        queue_probe(kc, 8'd3, 18'd99, 18'h1FFFF);
        // equal depth replaces; undefined kind never cuts off
        queue_store(kc, 18'd7, 8'd5, KIND_UNDEF, 7'h7F, 7'h7F, 8'd0);
        queue_probe(kc, 8'd0, 18'h1FFFF, 18'h20000);
        // different key in the same slot replaces regardless of depth
        queue_store(kb_alias, 18'd42, 8'd0, KIND_EXACT, 7'd5, 7'd6, 8'd7);
        queue_probe(kb, 8'd0, 18'd0, 18'd0);
        queue_probe(kb_alias, 8'd0, 18'd0, 18'd0);
        queue_store(64'd0, 18'h1FFFF, 8'd3, KIND_UPPER, 7'd63, 7'd63, 8'h80);
        queue_probe(64'd0, 8'd3, 18'h1FFFF, 18'h20000);
        queue_probe(64'd0, 8'd3, 18'h1FFFE, 18'h20000);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 72; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 72;
                end
                default:
                begin
                    send_idle_pct = 34; recv_stall_pct = 34;
                end
            endcase
            repeat (RANDOM_PER_PHASE) queue_random_item();
            // hold off new traffic until every pending probe result is back
            while (pending_requests.size() != 0 || s_axis_tvalid
                   || expected_probe_results.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end

        if (mismatches == 0 && expected_probe_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ttps_pkg.sv
hw/rtl/ttps_slot_mod.sv
hw/rtl/transposition_table_probe_store.sv
hw/rtl/ttps_checker.sv
verif/tb_transposition_table_probe_store.sv
